// ----- src/soa_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and tables for the slab object allocator.
// Depends on nothing; imported by the top level.
package soa_pkg;

   localparam int NUM_FRAMES   = 64;
   localparam int MAX_OBJECTS  = 64;
   localparam int CLASS_COUNT  = 11;
   localparam int HEADER_BYTES = 48;
   localparam int ALIGN_BYTES  = 16;

   localparam int SLAB_W  = 6;
   localparam int OBJ_W   = 6;
   localparam int CNT_W   = 7;
   localparam int CLS_W   = 4;
   localparam int LINK_W  = 7;
   localparam int SIZE_W  = 16;
   localparam int FIT_W   = 17;
   localparam int STAT_W  = 3;
   localparam int LIMIT_W = 7;

   localparam int GROUP_SIZE  = 8;
   localparam int GROUP_COUNT = NUM_FRAMES / GROUP_SIZE;
   localparam int GROUP_W     = 3;

   // Link word with the top bit set marks "no slab"
   localparam logic [LINK_W-1:0] LINK_NULL = 7'h40;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_ZERO_SIZE = 3'd1,
      STAT_TOO_LARGE = 3'd2,
      STAT_NO_FRAME  = 3'd3,
      STAT_BAD_FREE  = 3'd4
   } status_type;

   localparam logic [FIT_W-1:0] CLASS_BYTES [CLASS_COUNT] = '{
      17'd64, 17'd96, 17'd128, 17'd192, 17'd256, 17'd384,
      17'd512, 17'd768, 17'd1024, 17'd1536, 17'd2048
   };

   // Objects per slab: (page - header) / class bytes, capped at MAX_OBJECTS
   localparam logic [CNT_W-1:0] CLASS_OBJECTS [CLASS_COUNT] = '{
      7'd63, 7'd42, 7'd31, 7'd21, 7'd15, 7'd10, 7'd7, 7'd5, 7'd3, 7'd2, 7'd1
   };

   // Slab bookkeeping word kept in the metadata memory
   typedef struct packed {
      logic [CLS_W-1:0] cls;
      logic [CNT_W-1:0] free_cnt;
      logic [CNT_W-1:0] total;
   } meta_type;

   localparam int META_W = $bits(meta_type);

endpackage

// ----- src/soa_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No package dependency.
module soa_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/slab_object_allocator.sv -----
`timescale 1ns / 1ps
// Slab object allocator top level: sequencer, frame and list flags, CSR port.
// Depends on soa_pkg and soa_ram.
//
// Usage:
//  Request channel (req_*): op 0 allocates req_req_size bytes, op 1 frees
//  object req_free_object of slab req_free_slab. A word is taken when
//  req_valid is high and req_stall is low; req_stall stays high while one
//  request is in progress, so requests are handled one at a time.
//  Response channel (rsp_*): one word per request, held in an output
//  register until taken (rsp_valid high, rsp_stall low). The next request is
//  accepted while a response waits; a finished request waits in its last
//  step only if the previous response has not been taken.
//  An alloc that opens a new slab first fills the 64-entry free stack of
//  the slab, one stack entry per cycle.
//  Reset (synchronous, active high) frees all frames, empties the partial
//  lists and sets frame_limit to 64. Memories need no clearing pass.
//  CSR: register frame_limit at byte address 0, written through the APB port.
module slab_object_allocator (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_op,
   input  logic [15:0]             req_req_size,
   input  logic [5:0]              req_free_slab,
   input  logic [5:0]              req_free_object,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [5:0]              rsp_slab_index,
   output logic [5:0]              rsp_object_index,
   output logic [3:0]              rsp_class_index,
   output logic                    rsp_slab_released,
   // configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import soa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_A_READ, ST_A_META, ST_A_POP, ST_SCAN1, ST_SCAN2,
      ST_FILL, ST_ADD0, ST_ADD1, ST_F_CHK, ST_REM0, ST_REM1, ST_DONE
   } state_type;

   state_type              state_ff;
   logic [NUM_FRAMES-1:0]  in_use_ff;
   logic [NUM_FRAMES-1:0]  on_list_ff;
   logic [LINK_W-1:0]      head_ff [CLASS_COUNT];
   logic [LIMIT_W-1:0]     frame_limit_ff;

   // working registers of the current request
   logic                   op_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [SLAB_W-1:0]      slab_ff;
   logic [OBJ_W-1:0]       obj_ff;
   logic [CLS_W-1:0]       cls_ff;
   logic [CNT_W-1:0]       top_ff;
   logic [LINK_W-1:0]      h_ff;
   logic [CNT_W-1:0]       fill_ff;
   logic                   release_ff;
   logic                   after_free_ff;
   status_type             status_ff;
   logic [GROUP_COUNT-1:0] grp_any_ff;
   logic [GROUP_W-1:0]     grp_low_ff [GROUP_COUNT];

   // response register
   logic                   rsp_valid_ff;
   logic [STAT_W-1:0]      rsp_status_ff;
   logic [SLAB_W-1:0]      rsp_slab_ff;
   logic [OBJ_W-1:0]       rsp_obj_ff;
   logic [CLS_W-1:0]       rsp_cls_ff;
   logic                   rsp_rel_ff;

   // memory ports
   logic                       meta_we;
   logic [SLAB_W-1:0]          meta_waddr, meta_raddr;
   meta_type                   meta_wdata, meta_rd;
   logic [META_W-1:0]          meta_rd_bits;
   logic                       next_we, prev_we;
   logic [SLAB_W-1:0]          next_waddr, prev_waddr;
   logic [LINK_W-1:0]          next_wdata, prev_wdata, next_rd, prev_rd;
   logic                       stack_we, taken_we;
   logic [SLAB_W+OBJ_W-1:0]    stack_waddr, stack_raddr, taken_waddr, taken_raddr;
   logic [OBJ_W-1:0]           stack_wdata, stack_rd;
   logic                       taken_wdata, taken_rd;

   assign meta_rd = meta_type'(meta_rd_bits);

   soa_ram #(.ADDR_W(SLAB_W), .DATA_W(META_W)) u_meta (
      .clock, .wr_en(meta_we), .wr_addr(meta_waddr), .wr_data(META_W'(meta_wdata)),
      .rd_addr(meta_raddr), .rd_data(meta_rd_bits));
   soa_ram #(.ADDR_W(SLAB_W), .DATA_W(LINK_W)) u_next (
      .clock, .wr_en(next_we), .wr_addr(next_waddr), .wr_data(next_wdata),
      .rd_addr(slab_ff), .rd_data(next_rd));
   soa_ram #(.ADDR_W(SLAB_W), .DATA_W(LINK_W)) u_prev (
      .clock, .wr_en(prev_we), .wr_addr(prev_waddr), .wr_data(prev_wdata),
      .rd_addr(slab_ff), .rd_data(prev_rd));
   soa_ram #(.ADDR_W(SLAB_W+OBJ_W), .DATA_W(OBJ_W)) u_stack (
      .clock, .wr_en(stack_we), .wr_addr(stack_waddr), .wr_data(stack_wdata),
      .rd_addr(stack_raddr), .rd_data(stack_rd));
   soa_ram #(.ADDR_W(SLAB_W+OBJ_W), .DATA_W(1)) u_taken (
      .clock, .wr_en(taken_we), .wr_addr(taken_waddr), .wr_data(taken_wdata),
      .rd_addr(taken_raddr), .rd_data(taken_rd));

   // Size class decode from the registered request size
   logic [FIT_W-1:0] fit;
   logic [CLS_W-1:0] cls_dec;
   logic             cls_found;
   always_comb begin
      fit = (FIT_W'(size_ff) + FIT_W'(HEADER_BYTES + ALIGN_BYTES - 1))
            & ~FIT_W'(ALIGN_BYTES - 1);
      cls_dec   = '0;
      cls_found = 1'b0;
      for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
         if (fit <= CLASS_BYTES[c]) begin
            cls_dec   = CLS_W'(c);
            cls_found = 1'b1;
         end
      end
   end

   // Frames open for a new slab: not in use and below the clamped limit
   logic [LIMIT_W-1:0]    lim;
   logic [NUM_FRAMES-1:0] avail;
   always_comb begin
      lim = (frame_limit_ff > LIMIT_W'(NUM_FRAMES)) ? LIMIT_W'(NUM_FRAMES)
                                                      : frame_limit_ff;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         avail[i] = !in_use_ff[i] && (LIMIT_W'(i) < lim);
      end
   end

   // First stage of the lowest-free-frame search: per group of eight
   logic [GROUP_COUNT-1:0] grp_any;
   logic [GROUP_W-1:0]     grp_low [GROUP_COUNT];
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_any[g] = |avail[g*GROUP_SIZE +: GROUP_SIZE];
         grp_low[g] = '0;
         for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
            if (avail[g*GROUP_SIZE + b]) begin
               grp_low[g] = GROUP_W'(b);
            end
         end
      end
   end

   // Second stage: pick the lowest group
   logic [SLAB_W-1:0] pick;
   logic              pick_ok;
   always_comb begin
      pick    = '0;
      pick_ok = |grp_any_ff;
      for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pick = {GROUP_W'(g), grp_low_ff[g]};
         end
      end
   end

   logic [CNT_W-1:0] new_cnt;
   logic [CLS_W-1:0] free_cls;
   logic [CNT_W-1:0] free_cnt_inc;
   logic             free_bad;
   logic             out_free;
   assign new_cnt      = CLASS_OBJECTS[cls_ff];
   assign free_cls     = (meta_rd.cls >= CLS_W'(CLASS_COUNT)) ? '0 : meta_rd.cls;
   assign free_cnt_inc = meta_rd.free_cnt + 1'b1;
   assign free_bad     = ({1'b0, obj_ff} >= meta_rd.total) || !taken_rd;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Memory access for each step
   always_comb begin
      meta_we     = 1'b0;
      meta_waddr  = slab_ff;
      meta_wdata  = meta_rd;
      meta_raddr  = slab_ff;
      next_we     = 1'b0;
      next_waddr  = slab_ff;
      next_wdata  = h_ff;
      prev_we     = 1'b0;
      prev_waddr  = slab_ff;
      prev_wdata  = LINK_NULL;
      stack_we    = 1'b0;
      stack_waddr = {slab_ff, fill_ff[OBJ_W-1:0]};
      stack_wdata = fill_ff[OBJ_W-1:0];
      stack_raddr = {slab_ff, meta_rd.free_cnt[OBJ_W-1:0] - 1'b1};
      taken_we    = 1'b0;
      taken_waddr = {slab_ff, fill_ff[OBJ_W-1:0]};
      taken_wdata = 1'b0;
      taken_raddr = {slab_ff, obj_ff};
      unique case (state_ff)
         ST_DECODE: begin
            meta_raddr = op_ff ? slab_ff : head_ff[cls_dec][SLAB_W-1:0];
         end
         ST_A_META: begin
            // pop: count down and fetch the top of the stack
            meta_we    = (meta_rd.free_cnt != '0);
            meta_wdata = '{cls: meta_rd.cls, free_cnt: meta_rd.free_cnt - 1'b1,
                           total: meta_rd.total};
         end
         ST_A_POP: begin
            taken_we    = 1'b1;
            taken_waddr = {slab_ff, stack_rd};
            taken_wdata = 1'b1;
         end
         ST_SCAN2: begin
            meta_we    = pick_ok && (new_cnt != '0);
            meta_waddr = pick;
            meta_wdata = '{cls: cls_ff, free_cnt: new_cnt, total: new_cnt};
         end
         ST_FILL: begin
            stack_we = 1'b1;
            taken_we = 1'b1;
         end
         ST_ADD0: begin
            next_we    = !on_list_ff[slab_ff];
            next_wdata = head_ff[cls_ff];
            prev_we    = !on_list_ff[slab_ff];
         end
         ST_ADD1: begin
            prev_we    = !h_ff[LINK_W-1];
            prev_waddr = h_ff[SLAB_W-1:0];
            prev_wdata = {1'b0, slab_ff};
         end
         ST_F_CHK: begin
            // push: object goes on top, count up
            meta_we     = !free_bad;
            meta_wdata  = '{cls: meta_rd.cls, free_cnt: free_cnt_inc,
                            total: meta_rd.total};
            stack_we    = !free_bad;
            stack_waddr = {slab_ff, meta_rd.free_cnt[OBJ_W-1:0]};
            stack_wdata = obj_ff;
            taken_we    = !free_bad;
            taken_waddr = {slab_ff, obj_ff};
         end
         ST_REM1: begin
            // unlink: neighbors point past this slab
            next_we    = !prev_rd[LINK_W-1];
            next_waddr = prev_rd[SLAB_W-1:0];
            next_wdata = next_rd;
            prev_we    = !next_rd[LINK_W-1];
            prev_waddr = next_rd[SLAB_W-1:0];
            prev_wdata = prev_rd;
         end
         default: begin
         end
      endcase
   end

   // Sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         on_list_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CLASS_COUNT; c++) begin
            head_ff[c] <= LINK_NULL;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  size_ff  <= req_req_size;
                  slab_ff  <= req_free_slab;
                  obj_ff   <= req_free_object;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               release_ff    <= 1'b0;
               after_free_ff <= op_ff;
               if (op_ff) begin
                  if (!in_use_ff[slab_ff]) begin
                     status_ff <= STAT_BAD_FREE;
                     state_ff  <= ST_DONE;
                  end else begin
                     status_ff <= STAT_OK;
                     state_ff  <= ST_F_CHK;
                  end
               end else if (size_ff == '0) begin
                  status_ff <= STAT_ZERO_SIZE;
                  state_ff  <= ST_DONE;
               end else if (!cls_found) begin
                  status_ff <= STAT_TOO_LARGE;
                  state_ff  <= ST_DONE;
               end else begin
                  status_ff <= STAT_OK;
                  cls_ff    <= cls_dec;
                  if (head_ff[cls_dec][LINK_W-1]) begin
                     state_ff <= ST_SCAN1;
                  end else begin
                     slab_ff  <= head_ff[cls_dec][SLAB_W-1:0];
                     state_ff <= ST_A_META;
                  end
               end
            end
            ST_A_READ: begin
               state_ff <= ST_A_META;
            end
            ST_A_META: begin
               top_ff <= meta_rd.free_cnt - 1'b1;
               if (meta_rd.free_cnt == '0) begin
                  state_ff <= ST_SCAN1;
               end else begin
                  state_ff <= ST_A_POP;
               end
            end
            ST_A_POP: begin
               obj_ff   <= stack_rd;
               state_ff <= (top_ff == '0) ? ST_REM0 : ST_DONE;
            end
            ST_SCAN1: begin
               grp_any_ff <= grp_any;
               grp_low_ff <= grp_low;
               state_ff   <= ST_SCAN2;
            end
            ST_SCAN2: begin
               if (!pick_ok || new_cnt == '0) begin
                  status_ff <= STAT_NO_FRAME;
                  state_ff  <= ST_DONE;
               end else begin
                  slab_ff           <= pick;
                  in_use_ff[pick]   <= 1'b1;
                  on_list_ff[pick]  <= 1'b0;
                  fill_ff           <= '0;
                  state_ff          <= ST_FILL;
               end
            end
            ST_FILL: begin
               fill_ff <= fill_ff + 1'b1;
               if (fill_ff == CNT_W'(MAX_OBJECTS - 1)) begin
                  state_ff <= ST_ADD0;
               end
            end
            ST_ADD0: begin
               if (on_list_ff[slab_ff]) begin
                  h_ff <= LINK_NULL;
               end else begin
                  h_ff                <= head_ff[cls_ff];
                  head_ff[cls_ff]     <= {1'b0, slab_ff};
                  on_list_ff[slab_ff] <= 1'b1;
               end
               state_ff <= ST_ADD1;
            end
            ST_ADD1: begin
               if (!after_free_ff) begin
                  state_ff <= ST_A_READ;
               end else begin
                  state_ff <= release_ff ? ST_REM0 : ST_DONE;
               end
            end
            ST_F_CHK: begin
               if (free_bad) begin
                  status_ff <= STAT_BAD_FREE;
                  state_ff  <= ST_DONE;
               end else begin
                  cls_ff     <= free_cls;
                  release_ff <= (free_cnt_inc >= meta_rd.total);
                  if (free_cnt_inc >= meta_rd.total) begin
                     in_use_ff[slab_ff] <= 1'b0;
                  end
                  priority if (meta_rd.free_cnt == '0) begin
                     state_ff <= ST_ADD0;
                  end else if (free_cnt_inc >= meta_rd.total) begin
                     state_ff <= ST_REM0;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_REM0: begin
               state_ff <= on_list_ff[slab_ff] ? ST_REM1 : ST_DONE;
            end
            ST_REM1: begin
               if (prev_rd[LINK_W-1]) begin
                  head_ff[cls_ff] <= next_rd;
               end
               on_list_ff[slab_ff] <= 1'b0;
               state_ff            <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  if (status_ff == STAT_OK) begin
                     rsp_slab_ff <= slab_ff;
                     rsp_obj_ff  <= obj_ff;
                     rsp_cls_ff  <= cls_ff;
                     rsp_rel_ff  <= release_ff;
                  end else begin
                     rsp_slab_ff <= '0;
                     rsp_obj_ff  <= '0;
                     rsp_cls_ff  <= '0;
                     rsp_rel_ff  <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= LIMIT_W'(NUM_FRAMES);
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         frame_limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? '0 : {{(32-LIMIT_W){1'b0}}, frame_limit_ff};
   assign csr_pready = 1'b1;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slab_index    = rsp_slab_ff;
   assign rsp_object_index  = rsp_obj_ff;
   assign rsp_class_index   = rsp_cls_ff;
   assign rsp_slab_released = rsp_rel_ff;

   // Between requests a slab on a partial list is always in use
   a_list_in_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((on_list_ff & ~in_use_ff) == '0))
      else $error("slab on partial list while frame is free");

   // A good alloc or a keeping free leaves its slab in use when reported
   a_ok_in_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free && status_ff == STAT_OK && !release_ff)
      |=> in_use_ff[rsp_slab_index])
      else $error("reported slab is not in use");

   // Class of a good result is a real class
   a_ok_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_OK) |-> (rsp_cls_ff < CLS_W'(CLASS_COUNT)))
      else $error("result class out of range");

endmodule
